[hdl/lxtok_pkg.sv]
// Shared types and constants for the logic expression tokenizer.
// Holds token kinds, error codes, character codes and the queue entry type.
// No dependencies.
package lxtok_pkg;

   localparam int MAX_TOKENS = 64;
   localparam int CNT_W      = $clog2(MAX_TOKENS + 1);
   localparam int IDX_W      = 6;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_NUM  = 2'd0;
   localparam kind_type KIND_VAR  = 2'd1;
   localparam kind_type KIND_OP   = 2'd2;
   localparam kind_type KIND_TRUE = 2'd3;

   typedef logic [1:0] err_type;
   localparam err_type ERR_NONE    = 2'd0;
   localparam err_type ERR_ILLEGAL = 2'd1;
   localparam err_type ERR_POINT   = 2'd2;
   localparam err_type ERR_FULL    = 2'd3;

   localparam logic [7:0] CH_AND   = 8'h26;
   localparam logic [7:0] CH_NOT   = 8'h21;
   localparam logic [7:0] CH_OR    = 8'h7C;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_LP    = 8'h28;
   localparam logic [7:0] CH_RP    = 8'h29;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_TRUE  = 8'h74;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // Everything the back end needs to emit the results of one character.
   typedef struct packed {
      logic [7:0]       ch;
      logic             true_vld;
      logic             main_vld;
      kind_type         main_kind;
      logic             main_start;
      logic [IDX_W-1:0] main_idx;
      logic             term_vld;
      logic [IDX_W-1:0] term_idx;
      err_type          term_err;
   } plan_type;

endpackage

[hdl/lxtok_front.sv]
// Front end of the tokenizer: accepts characters, classifies them and keeps
// the scan state, token count and error latch. Pushes a plan for each character that yields a result.
// Depends on lxtok_pkg.
module lxtok_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] in_char
   input  logic                req_tlast,
   input  logic                fifo_full,
   output logic                push,
   output lxtok_pkg::plan_type plan
);

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_INT   = 3'd1,
      MODE_POINT = 3'd2,
      MODE_FRAC  = 3'd3,
      MODE_VAR   = 3'd4
   } mode_type;

   mode_type                       mode_ff, mode_in;
   logic [lxtok_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   lxtok_pkg::err_type             err_ff, err_in;

   logic [7:0]                     c;
   logic                           accept;
   logic                           c_op, c_not, c_digit, c_letter;
   logic                           full_now;
   logic [lxtok_pkg::CNT_W:0]      cnt_need;
   logic [lxtok_pkg::CNT_W-1:0]    cnt_dec;
   lxtok_pkg::err_type             err_step;
   mode_type                       mode_step;
   logic [lxtok_pkg::CNT_W-1:0]    cnt_step;

   assign c          = req_tdata;
   assign req_tready = !fifo_full;
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && (plan.true_vld || plan.main_vld || plan.term_vld);

   always_comb begin
      c_not    = (c == lxtok_pkg::CH_NOT);
      c_op     = c_not || (c == lxtok_pkg::CH_AND) || (c == lxtok_pkg::CH_OR) ||
                 (c == lxtok_pkg::CH_LT) || (c == lxtok_pkg::CH_GT) ||
                 (c == lxtok_pkg::CH_EQ) || (c == lxtok_pkg::CH_LP) ||
                 (c == lxtok_pkg::CH_RP) || (c == lxtok_pkg::CH_HASH);
      c_digit  = (c >= 8'h30) && (c <= 8'h39);
      c_letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
      full_now = (cnt_ff >= lxtok_pkg::CNT_W'(lxtok_pkg::MAX_TOKENS));
      cnt_need = {1'b0, cnt_ff} + (c_not ? (lxtok_pkg::CNT_W+1)'(2) : (lxtok_pkg::CNT_W+1)'(1));
      cnt_dec  = cnt_ff - lxtok_pkg::CNT_W'(1);

      mode_step = mode_ff;
      cnt_step  = cnt_ff;
      err_step  = err_ff;

      plan            = '0;
      plan.ch         = c;
      plan.main_kind  = lxtok_pkg::KIND_NUM;
      plan.term_err   = lxtok_pkg::ERR_NONE;

      if (err_ff == lxtok_pkg::ERR_NONE) begin
         if (c == lxtok_pkg::CH_SPACE) begin
            if (mode_ff == MODE_POINT) err_step = lxtok_pkg::ERR_POINT;
            else                       mode_step = MODE_IDLE;
         end else if (c_op) begin
            if (mode_ff == MODE_POINT) begin
               err_step = lxtok_pkg::ERR_POINT;
            end else if (cnt_need > (lxtok_pkg::CNT_W+1)'(lxtok_pkg::MAX_TOKENS)) begin
               err_step = lxtok_pkg::ERR_FULL;
            end else begin
               // A negation is preceded by an implicit true token one index lower.
               plan.true_vld   = c_not;
               plan.main_vld   = 1'b1;
               plan.main_kind  = lxtok_pkg::KIND_OP;
               plan.main_start = 1'b1;
               plan.main_idx   = lxtok_pkg::IDX_W'(cnt_need - (lxtok_pkg::CNT_W+1)'(1));
               cnt_step        = lxtok_pkg::CNT_W'(cnt_need);
               mode_step       = MODE_IDLE;
            end
         end else if (c_digit) begin
            if (mode_ff == MODE_INT || mode_ff == MODE_FRAC || mode_ff == MODE_POINT) begin
               plan.main_vld  = 1'b1;
               plan.main_kind = lxtok_pkg::KIND_NUM;
               plan.main_idx  = lxtok_pkg::IDX_W'(cnt_dec);
               if (mode_ff == MODE_POINT) mode_step = MODE_FRAC;
            end else if (full_now) begin
               err_step = lxtok_pkg::ERR_FULL;
            end else begin
               plan.main_vld   = 1'b1;
               plan.main_kind  = lxtok_pkg::KIND_NUM;
               plan.main_start = 1'b1;
               plan.main_idx   = lxtok_pkg::IDX_W'(cnt_ff);
               cnt_step        = cnt_ff + lxtok_pkg::CNT_W'(1);
               mode_step       = MODE_INT;
            end
         end else if (c_letter) begin
            if (mode_ff == MODE_POINT) begin
               err_step = lxtok_pkg::ERR_POINT;
            end else if (mode_ff == MODE_VAR) begin
               plan.main_vld  = 1'b1;
               plan.main_kind = lxtok_pkg::KIND_VAR;
               plan.main_idx  = lxtok_pkg::IDX_W'(cnt_dec);
            end else if (full_now) begin
               err_step = lxtok_pkg::ERR_FULL;
            end else begin
               plan.main_vld   = 1'b1;
               plan.main_kind  = lxtok_pkg::KIND_VAR;
               plan.main_start = 1'b1;
               plan.main_idx   = lxtok_pkg::IDX_W'(cnt_ff);
               cnt_step        = cnt_ff + lxtok_pkg::CNT_W'(1);
               mode_step       = MODE_VAR;
            end
         end else if (c == lxtok_pkg::CH_POINT) begin
            if (mode_ff == MODE_INT) begin
               plan.main_vld  = 1'b1;
               plan.main_kind = lxtok_pkg::KIND_NUM;
               plan.main_idx  = lxtok_pkg::IDX_W'(cnt_dec);
               mode_step      = MODE_POINT;
            end else if (mode_ff == MODE_POINT) begin
               err_step = lxtok_pkg::ERR_POINT;
            end else begin
               err_step = lxtok_pkg::ERR_ILLEGAL;
            end
         end else begin
            err_step = (mode_ff == MODE_POINT) ? lxtok_pkg::ERR_POINT : lxtok_pkg::ERR_ILLEGAL;
         end
      end

      mode_in = mode_step;
      cnt_in  = cnt_step;
      err_in  = err_step;

      // The terminator closes the expression and the scan state starts over.
      if (req_tlast) begin
         if (err_in == lxtok_pkg::ERR_NONE && mode_step == MODE_POINT)
            err_in = lxtok_pkg::ERR_POINT;
         if (err_in == lxtok_pkg::ERR_NONE &&
             cnt_step >= lxtok_pkg::CNT_W'(lxtok_pkg::MAX_TOKENS))
            err_in = lxtok_pkg::ERR_FULL;
         plan.term_vld = 1'b1;
         plan.term_idx = lxtok_pkg::IDX_W'(cnt_step);
         plan.term_err = err_in;
         mode_in       = MODE_IDLE;
         cnt_in        = '0;
         err_in        = lxtok_pkg::ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         cnt_ff  <= '0;
         err_ff  <= lxtok_pkg::ERR_NONE;
      end else if (accept) begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         err_ff  <= err_in;
      end
   end

endmodule

[hdl/lxtok_fifo.sv]
// Short queue of per-character plans between the front and back ends.
// Register array with a combinational read of the head entry.
// Depends on lxtok_pkg.
module lxtok_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  lxtok_pkg::plan_type           wr_data,
   input  logic                          pop,
   output lxtok_pkg::plan_type           rd_data,
   output logic                          full,
   output logic                          empty,
   output logic [lxtok_pkg::FIFO_CW-1:0] count
);

   lxtok_pkg::plan_type                  entry_ff [lxtok_pkg::FIFO_DEPTH];
   logic [lxtok_pkg::FIFO_AW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [lxtok_pkg::FIFO_AW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [lxtok_pkg::FIFO_CW-1:0]        count_ff, count_in;

   assign count   = count_ff;
   assign full    = (count_ff == lxtok_pkg::FIFO_CW'(lxtok_pkg::FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + lxtok_pkg::FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + lxtok_pkg::FIFO_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + lxtok_pkg::FIFO_CW'(1);
         2'b01:   count_in = count_ff - lxtok_pkg::FIFO_CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[hdl/lxtok_back.sv]
// Back end of the tokenizer: unpacks each queued plan into up to three
// result beats and drives the registered result channel.
// Depends on lxtok_pkg.
module lxtok_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                fifo_empty,
   input  lxtok_pkg::plan_type head,
   output logic                fifo_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,  // [7:0] token_char, [13:8] token_index,
                                           // [15:14] error_code
   output logic [2:0]          rsp_tuser,  // [1:0] token_kind, [2] token_start
   output logic                rsp_tlast   // is_last
);

   lxtok_pkg::plan_type             cur_ff, cur_in;
   logic [2:0]                      pend_ff, pend_in, pend_next;
   logic                            emit, load_out;

   logic                            valid_ff, valid_in;
   logic [15:0]                     data_ff, data_in;
   logic [2:0]                      user_ff, user_in;
   logic                            last_ff, last_in;

   logic [7:0]                      sel_ch;
   lxtok_pkg::kind_type             sel_kind;
   logic                            sel_start;
   logic [lxtok_pkg::IDX_W-1:0]     sel_idx;
   lxtok_pkg::err_type              sel_err;
   logic                            sel_last;

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

   always_comb begin
      load_out = !valid_ff || rsp_tready;
      emit     = load_out && (pend_ff != '0);

      // Pending bits go out lowest first: implicit true, main, terminator.
      sel_ch    = cur_ff.ch;
      sel_kind  = cur_ff.main_kind;
      sel_start = cur_ff.main_start;
      sel_idx   = cur_ff.main_idx;
      sel_err   = lxtok_pkg::ERR_NONE;
      sel_last  = 1'b0;
      if (pend_ff[0]) begin
         sel_ch    = lxtok_pkg::CH_TRUE;
         sel_kind  = lxtok_pkg::KIND_TRUE;
         sel_start = 1'b1;
         sel_idx   = cur_ff.main_idx - lxtok_pkg::IDX_W'(1);
      end else if (!pend_ff[1]) begin
         sel_ch    = lxtok_pkg::CH_HASH;
         sel_kind  = lxtok_pkg::KIND_OP;
         sel_start = 1'b1;
         sel_idx   = cur_ff.term_idx;
         sel_err   = cur_ff.term_err;
         sel_last  = 1'b1;
      end

      // Clearing the lowest set bit retires the beat just sent.
      pend_next = emit ? (pend_ff & (pend_ff - 3'd1)) : pend_ff;
      fifo_pop  = !fifo_empty && (pend_next == '0);

      if (fifo_pop) begin
         cur_in  = head;
         pend_in = {head.term_vld, head.main_vld, head.true_vld};
      end else begin
         cur_in  = cur_ff;
         pend_in = pend_next;
      end

      valid_in = valid_ff;
      data_in  = data_ff;
      user_in  = user_ff;
      last_in  = last_ff;
      if (emit) begin
         valid_in = 1'b1;
         data_in  = {sel_err, sel_idx, sel_ch};
         user_in  = {sel_start, sel_kind};
         last_in  = sel_last;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      data_ff <= data_in;
      user_ff <= user_in;
      last_ff <= last_in;
   end

endmodule

[hdl/logic_expression_tokenizer.sv]
// Logic expression tokenizer, top level.
// Depends on lxtok_pkg, lxtok_front, lxtok_fifo and lxtok_back.
//
// The req channel takes one expression character per beat; tlast marks the
// last character. The rsp channel returns the token characters, each tagged
// with its kind, a start flag, the token index and an error code, and a
// closing '#' beat with tlast set after the last character.
// A character enters in every cycle while the plan queue has room. Each
// character yields zero to three result beats; the result port sends one
// beat per cycle while the receiver is ready, so sustained input rate is one
// character per cycle as long as characters average one beat or fewer; a
// negation yields two beats and a final character adds a terminator beat.
// The first beat of a character passes through the four-entry plan queue
// and the back end's plan register, after which the result register holds it.
// When the receiver stalls, the result register holds its beat, the back
// end stops draining the queue, and req_tready falls once the queue is full.
// Reset clears the scan state, the queue and the result valid; no result
// is pending afterwards.
module logic_expression_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_char
   input  logic        req_tlast,   // end_of_expr
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] token_char, [13:8] token_index,
                                    // [15:14] error_code
   output logic [2:0]  rsp_tuser,   // [1:0] token_kind, [2] token_start
   output logic        rsp_tlast    // is_last
);

   lxtok_pkg::plan_type                  push_plan, head_plan;
   logic                                 fifo_push, fifo_pop;
   logic                                 fifo_full, fifo_empty;
   logic [lxtok_pkg::FIFO_CW-1:0]        fifo_count;

   lxtok_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .fifo_full  (fifo_full),
      .push       (fifo_push),
      .plan       (push_plan)
   );

   lxtok_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (fifo_push),
      .wr_data (push_plan),
      .pop     (fifo_pop),
      .rd_data (head_plan),
      .full    (fifo_full),
      .empty   (fifo_empty),
      .count   (fifo_count)
   );

   lxtok_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .head       (head_plan),
      .fifo_pop   (fifo_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef ASSERT_OFF
   a_err_only_on_term: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[15:14] != lxtok_pkg::ERR_NONE) |->
         rsp_tlast && (rsp_tdata[7:0] == lxtok_pkg::CH_HASH))
      else $error("error code on a beat that is not the terminator");

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (fifo_count == lxtok_pkg::FIFO_CW'(lxtok_pkg::FIFO_DEPTH)))
      else $error("input stalled while the plan queue has room");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      fifo_pop |-> !fifo_empty)
      else $error("plan queue popped while empty");
`endif

endmodule

[test/testbench.sv]
// Self-checking testbench for logic_expression_tokenizer.
// Depends on lxtok_pkg and the tokenizer RTL. A scoreboard class predicts
// the token beats of every accepted character and checks the rsp stream.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RUN_LIMIT  = 200000;
   localparam int LONG_HOLD  = 80;
   localparam int DRAIN_WAIT = 10;

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_INT,
      SCAN_POINT,
      SCAN_FRAC,
      SCAN_VAR
   } scan_mode_type;

   typedef struct packed {
      logic [7:0]                  ch;
      lxtok_pkg::kind_type         kind;
      logic                        start;
      logic [lxtok_pkg::IDX_W-1:0] idx;
      lxtok_pkg::err_type          err;
      logic                        last;
   } token_beat_type;

   // Predicts the token beats of each character and matches them in order.
   class token_ledger;
      scan_mode_type       mode;
      int unsigned         opened;
      lxtok_pkg::err_type  fault;
      token_beat_type      owed[$];
      int unsigned         failures;

      function new();
         restart();
         failures = 0;
      endfunction

      function void restart();
         mode   = SCAN_IDLE;
         opened = 0;
         fault  = lxtok_pkg::ERR_NONE;
      endfunction

      function void owe(logic [7:0] ch, lxtok_pkg::kind_type kind, logic start,
                        int unsigned idx, lxtok_pkg::err_type err, logic last);
         token_beat_type b;
         b.ch    = ch;
         b.kind  = kind;
         b.start = start;
         b.idx   = idx[lxtok_pkg::IDX_W-1:0];
         b.err   = err;
         b.last  = last;
         owed.push_back(b);
      endfunction

      function void open_token(logic [7:0] c, lxtok_pkg::kind_type kind,
                               scan_mode_type next);
         if (opened >= lxtok_pkg::MAX_TOKENS) begin
            fault = lxtok_pkg::ERR_FULL;
         end else begin
            owe(c, kind, 1'b1, opened, lxtok_pkg::ERR_NONE, 1'b0);
            opened++;
            mode = next;
         end
      endfunction

      function void take_char(logic [7:0] c, logic last);
         int unsigned need;
         bit          digit, letter;
         digit  = (c >= "0" && c <= "9");
         letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
         if (fault == lxtok_pkg::ERR_NONE) begin
            if (c == lxtok_pkg::CH_SPACE) begin
               if (mode == SCAN_POINT) fault = lxtok_pkg::ERR_POINT;
               else mode = SCAN_IDLE;
            end else if (c inside {lxtok_pkg::CH_AND, lxtok_pkg::CH_NOT, lxtok_pkg::CH_OR,
                                   lxtok_pkg::CH_LT, lxtok_pkg::CH_GT, lxtok_pkg::CH_EQ,
                                   lxtok_pkg::CH_LP, lxtok_pkg::CH_RP,
                                   lxtok_pkg::CH_HASH}) begin
               need = (c == lxtok_pkg::CH_NOT) ? 2 : 1;
               if (mode == SCAN_POINT) begin
                  fault = lxtok_pkg::ERR_POINT;
               end else if (opened + need > lxtok_pkg::MAX_TOKENS) begin
                  fault = lxtok_pkg::ERR_FULL;
               end else begin
                  // A negation gets an implicit true operand in front of it.
                  if (c == lxtok_pkg::CH_NOT) begin
                     owe(lxtok_pkg::CH_TRUE, lxtok_pkg::KIND_TRUE, 1'b1, opened,
                         lxtok_pkg::ERR_NONE, 1'b0);
                     opened++;
                  end
                  owe(c, lxtok_pkg::KIND_OP, 1'b1, opened, lxtok_pkg::ERR_NONE, 1'b0);
                  opened++;
                  mode = SCAN_IDLE;
               end
            end else if (digit) begin
               if (mode == SCAN_INT || mode == SCAN_FRAC) begin
                  owe(c, lxtok_pkg::KIND_NUM, 1'b0, opened - 1, lxtok_pkg::ERR_NONE, 1'b0);
               end else if (mode == SCAN_POINT) begin
                  owe(c, lxtok_pkg::KIND_NUM, 1'b0, opened - 1, lxtok_pkg::ERR_NONE, 1'b0);
                  mode = SCAN_FRAC;
               end else begin
                  open_token(c, lxtok_pkg::KIND_NUM, SCAN_INT);
               end
            end else if (letter) begin
               if (mode == SCAN_POINT) begin
                  fault = lxtok_pkg::ERR_POINT;
               end else if (mode == SCAN_VAR) begin
                  owe(c, lxtok_pkg::KIND_VAR, 1'b0, opened - 1, lxtok_pkg::ERR_NONE, 1'b0);
               end else begin
                  open_token(c, lxtok_pkg::KIND_VAR, SCAN_VAR);
               end
            end else if (c == lxtok_pkg::CH_POINT) begin
               if (mode == SCAN_INT) begin
                  owe(c, lxtok_pkg::KIND_NUM, 1'b0, opened - 1, lxtok_pkg::ERR_NONE, 1'b0);
                  mode = SCAN_POINT;
               end else if (mode == SCAN_POINT) begin
                  fault = lxtok_pkg::ERR_POINT;
               end else begin
                  fault = lxtok_pkg::ERR_ILLEGAL;
               end
            end else begin
               fault = (mode == SCAN_POINT) ? lxtok_pkg::ERR_POINT : lxtok_pkg::ERR_ILLEGAL;
            end
         end
         if (last) begin
            if (fault == lxtok_pkg::ERR_NONE && mode == SCAN_POINT)
               fault = lxtok_pkg::ERR_POINT;
            if (fault == lxtok_pkg::ERR_NONE && opened >= lxtok_pkg::MAX_TOKENS)
               fault = lxtok_pkg::ERR_FULL;
            owe(lxtok_pkg::CH_HASH, lxtok_pkg::KIND_OP, 1'b1, opened, fault, 1'b1);
            restart();
         end
      endfunction

      function void match_beat(logic [15:0] data, logic [2:0] user, logic tl);
         token_beat_type got, want;
         got.ch    = data[7:0];
         got.idx   = data[13:8];
         got.err   = data[15:14];
         got.kind  = user[1:0];
         got.start = user[2];
         got.last  = tl;
         if (owed.size() == 0) begin
            $display("%0t: unexpected token beat, expected none, got %p", $time, got);
            failures++;
            return;
         end
         want = owed.pop_front();
         if (got.ch !== want.ch)
            $display("%0t: token_char expected %h got %h", $time, want.ch, got.ch);
         if (got.kind !== want.kind)
            $display("%0t: token_kind expected %0d got %0d", $time, want.kind, got.kind);
         if (got.start !== want.start)
            $display("%0t: token_start expected %b got %b", $time, want.start, got.start);
         if (got.idx !== want.idx)
            $display("%0t: token_index expected %0d got %0d", $time, want.idx, got.idx);
         if (got.err !== want.err)
            $display("%0t: error_code expected %0d got %0d", $time, want.err, got.err);
         if (got.last !== want.last)
            $display("%0t: is_last expected %b got %b", $time, want.last, got.last);
         if (got !== want) failures++;
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] in_char
   logic        req_tlast  = 1'b0;    // end_of_expr
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [7:0] token_char, [13:8] token_index,
                                      // [15:14] error_code
   logic [2:0]  rsp_tuser;            // [1:0] token_kind, [2] token_start
   logic        rsp_tlast;            // is_last

   token_ledger ledger = new();
   int          req_max_gap   = 13;
   int          rsp_max_stall = 13;
   bit          hold_rsp      = 1'b0;
   int unsigned chars_sent    = 0;

   logic [7:0]  op_chars[9] = '{lxtok_pkg::CH_AND, lxtok_pkg::CH_OR, lxtok_pkg::CH_LT,
                                lxtok_pkg::CH_GT, lxtok_pkg::CH_EQ, lxtok_pkg::CH_LP,
                                lxtok_pkg::CH_RP, lxtok_pkg::CH_HASH, lxtok_pkg::CH_NOT};

   logic_expression_tokenizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int draw_gap(int max_gap);
      if (max_gap == 0 || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, max_gap);
   endfunction

   // Receiver: random stalls per beat, plus one long hold-off on request.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp = 1'b0;
         end
         stall = draw_gap(rsp_max_stall);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) ledger.match_beat(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < RUN_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send_char(logic [7:0] c, logic last);
      int gap;
      gap = draw_gap(req_max_gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      ledger.take_char(c, last);
      chars_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   // The sender goes idle so the last character is not offered again.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (ledger.owed.size() != 0) @(posedge clock);
   endtask

   // Random tokens; about three in eight get a random byte or a point put in.
   task automatic send_random_expr();
      logic [7:0] text[$];
      int         n_tok, pos;
      n_tok = $urandom_range(1, 6);
      for (int t = 0; t < n_tok; t++) begin
         case ($urandom_range(0, 3))
            0: repeat ($urandom_range(1, 3))
                  text.push_back(8'($urandom_range(0, 1) ? $urandom_range("a", "z")
                                                         : $urandom_range("A", "Z")));
            1: begin
               repeat ($urandom_range(1, 3)) text.push_back(8'("0" + $urandom_range(0, 9)));
               if ($urandom_range(0, 1)) begin
                  text.push_back(lxtok_pkg::CH_POINT);
                  repeat ($urandom_range(1, 2))
                     text.push_back(8'("0" + $urandom_range(0, 9)));
               end
            end
            2: text.push_back(op_chars[$urandom_range(0, 8)]);
            default: text.push_back(lxtok_pkg::CH_SPACE);
         endcase
      end
      case ($urandom_range(0, 7))
         0: text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
         1: text[$urandom_range(0, text.size() - 1)] = lxtok_pkg::CH_POINT;
         2: begin
            pos = $urandom_range(0, text.size());
            text.insert(pos, lxtok_pkg::CH_POINT);
            text.insert(pos, 8'("0" + $urandom_range(0, 9)));
         end
         default: ;
      endcase
      foreach (text[i]) send_char(text[i], i == text.size() - 1);
   endtask

   // Fills the token budget with negations, two tokens each, then sends the tail.
   task automatic send_crowded(int n_nots, string tail);
      repeat (n_nots) send_char(lxtok_pkg::CH_NOT, 1'b0);
      send_text(tail);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: every operator except '|', implicit true, number/variable switches,
      // point errors, illegal bytes, and an error on the last character.
      send_text("x9&!(1.25b)<>= #");
      send_text("7.");
      send_char(8'h00, 1'b1);
      send_char("q", 1'b0);
      send_char(8'hFF, 1'b1);
      send_text("1.2.");
      send_text(".5");
      send_text("3.x");

      // Receiver holds off while the sender bursts, so the input backs up.
      wait_drained();
      hold_rsp    = 1'b1;
      req_max_gap = 0;
      send_text("alpha & !beta | 12.5 > x1 = (z9)");
      req_max_gap = 13;
      send_random_expr();

      // Sender pauses until every token beat has come back.
      wait_drained();
      while (chars_sent < 75) send_random_expr();

      // Token budget edge, sent with no idling on either side: the last
      // negation fills the budget, the digit finds no slot left.
      req_max_gap   = 0;
      rsp_max_stall = 0;
      send_crowded(31, "!5");
      req_max_gap   = 13;
      rsp_max_stall = 13;
      repeat (2) send_random_expr();

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (ledger.failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
